// ----- rtl/jddm_pkg.sv -----
// ----------------------------------------------------------------------------
// jddm_pkg: shared constants for the joystick differential drive mixer
// Axis formats, datapath widths, pipeline depths, register indexes and reset values.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // Axis fraction bits; full scale is UNITY
  localparam int FRAC       = 15;
  localparam int UNITY      = 1 << FRAC;

  localparam int AXIS_W     = FRAC + 1;      // input axis, signed
  localparam int MAG_W      = FRAC + 1;      // axis magnitude, holds UNITY
  localparam int SHP_W      = FRAC + 2;      // shaped axis, signed, +/- UNITY
  localparam int DB_W       = FRAC;          // dead band, tolerance, turn gain
  localparam int DEN_W      = FRAC + 1;      // UNITY - dead_band
  localparam int NUM_W      = 2 * FRAC;      // deadzone dividend
  localparam int QUO_W      = FRAC + 1;      // deadzone quotient, up to UNITY
  localparam int DIV_STAGES = QUO_W;         // one quotient bit per stage

  localparam int GAIN_W     = 10;
  localparam int DRIVE_W    = GAIN_W + 1;

  // Shaper: magnitude, dividend, divider steps, sign restore
  localparam int SHAPE_LAT  = DIV_STAGES + 3;
  // Mixer: products, turn product, sums, magnitude, round/clamp
  localparam int MIX_LAT    = 5;
  localparam int PIPE_DEPTH = SHAPE_LAT + MIX_LAT;

  // Register file
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FORWARD_GAIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_GAIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TURN_GAIN      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_TOLERANCE = 3'd4;

  localparam logic [DB_W-1:0]   RST_DEAD_BAND      = 15'd1638;
  localparam logic [GAIN_W-1:0] RST_FORWARD_GAIN   = 10'd167;
  localparam logic [GAIN_W-1:0] RST_REVERSE_GAIN   = 10'd167;
  localparam logic [DB_W-1:0]   RST_TURN_GAIN      = 15'd16384;
  localparam logic [DB_W-1:0]   RST_SPIN_TOLERANCE = 15'd3277;

endpackage

// ----- rtl/jddm_shape.sv -----
// ----------------------------------------------------------------------------
// jddm_shape: axis deadzone shaper
// Saturated magnitude, deadzone test and a restoring divider with one
// quotient bit per stage computing (|v|-dz)*UNITY/(UNITY-dz), rounded half up.
// ----------------------------------------------------------------------------
module jddm_shape
  import jddm_pkg::*;
(
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [AXIS_W-1:0] axis,
  input  logic [DB_W-1:0]          dead_band,
  output logic signed [SHP_W-1:0]  shaped
);

  logic [AXIS_W-1:0] axis_u;
  logic [MAG_W-1:0]  mag_in;
  logic              neg_a;
  logic [MAG_W-1:0]  mag_a;

  logic [DEN_W-1:0]  den;
  logic [MAG_W-1:0]  diff;
  logic [NUM_W-1:0]  num;

  // stage 0 of these arrays is the dividend stage, the rest follow each step
  logic [NUM_W-1:0]  rem   [0:DIV_STAGES];
  logic [QUO_W-1:0]  quo   [0:DIV_STAGES];
  logic [MAG_W-1:0]  mag_p [0:DIV_STAGES];
  logic              neg_p [0:DIV_STAGES];
  logic              byp_p [0:DIV_STAGES];
  logic              zro_p [0:DIV_STAGES];

  logic [NUM_W:0]    dsh      [0:DIV_STAGES-1];
  logic              ge       [0:DIV_STAGES-1];
  logic [NUM_W-1:0]  rem_next [0:DIV_STAGES-1];
  logic [QUO_W-1:0]  quo_next [0:DIV_STAGES-1];

  logic [QUO_W-1:0]  fval;
  logic [SHP_W-1:0]  fpos;

  // -32768 maps to UNITY in 16 bits
  assign axis_u = axis;
  assign mag_in = axis_u[AXIS_W-1] ? (~axis_u + 1'b1) : axis_u;

  assign den  = DEN_W'(UNITY) - DEN_W'(dead_band);
  assign diff = mag_a - MAG_W'(dead_band);
  assign num  = (NUM_W'(diff[FRAC-1:0]) << FRAC) + NUM_W'(den >> 1);

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dsh[k]      = (NUM_W+1)'(den) << (DIV_STAGES - 1 - k);
      ge[k]       = {1'b0, rem[k]} >= dsh[k];
      rem_next[k] = ge[k] ? (rem[k] - dsh[k][NUM_W-1:0]) : rem[k];
      quo_next[k] = quo[k];
      quo_next[k][DIV_STAGES-1-k] = ge[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_a <= axis_u[AXIS_W-1];
      mag_a <= mag_in;

      rem[0]   <= num;
      quo[0]   <= '0;
      mag_p[0] <= mag_a;
      neg_p[0] <= neg_a;
      byp_p[0] <= (dead_band == '0);
      zro_p[0] <= (mag_a <= MAG_W'(dead_band));

      for (int k = 0; k < DIV_STAGES; k++) begin
        rem[k+1]   <= rem_next[k];
        quo[k+1]   <= quo_next[k];
        mag_p[k+1] <= mag_p[k];
        neg_p[k+1] <= neg_p[k];
        byp_p[k+1] <= byp_p[k];
        zro_p[k+1] <= zro_p[k];
      end

      shaped <= neg_p[DIV_STAGES] ? signed'(~fpos + 1'b1) : signed'(fpos);
    end
  end

  always_comb begin
    if (byp_p[DIV_STAGES]) begin
      fval = mag_p[DIV_STAGES];
    end else if (zro_p[DIV_STAGES]) begin
      fval = '0;
    end else begin
      fval = quo[DIV_STAGES];
    end
    fpos = {1'b0, fval};
  end

endmodule

// ----- rtl/joystick_differential_drive_mix.sv -----
// ----------------------------------------------------------------------------
// joystick_differential_drive_mix: arcade drive mixer
// Depth: 24 register stages (19 in the per-axis deadzone shaper, 5 in the
// mixer); out_valid rises as the result reaches the last of them.
// Throughput: one transaction per cycle; the pipeline holds while out_stall
// keeps a finished result waiting. Reset clears the valid bits and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mix
  import jddm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [AXIS_W-1:0] axis_turn,
  input  logic signed [AXIS_W-1:0] axis_throttle,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DRIVE_W-1:0] left_drive,
  output logic signed [DRIVE_W-1:0] right_drive,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int PRD_W = SHP_W + GAIN_W + 1;
  localparam int MIX_W = PRD_W + DB_W + 1;
  localparam int QR_W  = MIX_W - 2 * FRAC;

  typedef enum logic [2:0] {
    MIX_STOP,
    MIX_SPIN,
    MIX_B_SUB,
    MIX_A_ADD,
    MIX_B_ADD,
    MIX_A_SUB
  } mix_t;

  // registers
  logic [DB_W-1:0]   dead_band;
  logic [GAIN_W-1:0] forward_gain;
  logic [GAIN_W-1:0] reverse_gain;
  logic [DB_W-1:0]   turn_gain;
  logic [DB_W-1:0]   spin_tolerance;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  adv;

  logic signed [SHP_W-1:0] x;
  logic signed [SHP_W-1:0] y;

  // mixer stage 1
  logic [GAIN_W-1:0]       g;
  logic [MAG_W-1:0]        xabs;
  logic                    spin;
  mix_t                    code_next;
  logic signed [PRD_W-1:0] xg;
  logic signed [PRD_W-1:0] pg;
  mix_t                    code1;

  // mixer stage 2
  logic signed [MIX_W-1:0] p2;
  logic signed [MIX_W-1:0] t2;
  mix_t                    code2;

  // sums, magnitudes
  logic signed [MIX_W-1:0] a_next;
  logic signed [MIX_W-1:0] b_next;
  logic signed [MIX_W-1:0] a3;
  logic signed [MIX_W-1:0] b3;
  logic                    na;
  logic                    nb;
  logic [MIX_W-1:0]        ma;
  logic [MIX_W-1:0]        mb;

  function automatic logic signed [DRIVE_W-1:0] drive_round(
    input logic             neg,
    input logic [MIX_W-1:0] mag,
    input logic [GAIN_W-1:0] lim
  );
    logic [MIX_W-1:0]   rsum;
    logic [QR_W-1:0]    q;
    logic [GAIN_W-1:0]  qc;
    logic [DRIVE_W-1:0] r;
    rsum = mag + (MIX_W'(1) << (2 * FRAC - 1));
    q    = rsum[MIX_W-1:2*FRAC];
    qc   = (q > QR_W'(lim)) ? lim : q[GAIN_W-1:0];
    r    = neg ? (~{1'b0, qc} + 1'b1) : {1'b0, qc};
    return signed'(r);
  endfunction

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band      <= RST_DEAD_BAND;
      forward_gain   <= RST_FORWARD_GAIN;
      reverse_gain   <= RST_REVERSE_GAIN;
      turn_gain      <= RST_TURN_GAIN;
      spin_tolerance <= RST_SPIN_TOLERANCE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEAD_BAND:      dead_band      <= pwdata[DB_W-1:0];
        REG_FORWARD_GAIN:   forward_gain   <= pwdata[GAIN_W-1:0];
        REG_REVERSE_GAIN:   reverse_gain   <= pwdata[GAIN_W-1:0];
        REG_TURN_GAIN:      turn_gain      <= pwdata[DB_W-1:0];
        REG_SPIN_TOLERANCE: spin_tolerance <= pwdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEAD_BAND:      prdata = DATA_W'(dead_band);
      REG_FORWARD_GAIN:   prdata = DATA_W'(forward_gain);
      REG_REVERSE_GAIN:   prdata = DATA_W'(reverse_gain);
      REG_TURN_GAIN:      prdata = DATA_W'(turn_gain);
      REG_SPIN_TOLERANCE: prdata = DATA_W'(spin_tolerance);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // everything moves together unless the finished result is held
  assign adv       = !(vld[PIPE_DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // ---------------- axis shaping ----------------
  jddm_shape u_shape_turn (
    .clk       (clk),
    .adv       (adv),
    .axis      (axis_turn),
    .dead_band (dead_band),
    .shaped    (x)
  );

  jddm_shape u_shape_throttle (
    .clk       (clk),
    .adv       (adv),
    .axis      (axis_throttle),
    .dead_band (dead_band),
    .shaped    (y)
  );

  // ---------------- mixer ----------------
  assign g    = y[SHP_W-1] ? reverse_gain : forward_gain;
  assign xabs = x[SHP_W-1] ? MAG_W'(-x) : MAG_W'(x);
  assign spin = (spin_tolerance != '0) && (xabs >= MAG_W'(spin_tolerance));

  always_comb begin
    if (y[SHP_W-1]) begin
      code_next = x[SHP_W-1] ? MIX_A_SUB : MIX_B_ADD;
    end else if (y != '0) begin
      code_next = x[SHP_W-1] ? MIX_A_ADD : MIX_B_SUB;
    end else begin
      code_next = spin ? MIX_SPIN : MIX_STOP;
    end
  end

  // a is the right wheel, b the left; the inner wheel takes the turn term
  always_comb begin
    case (code2)
      MIX_B_SUB: begin
        a_next = p2;
        b_next = p2 - t2;
      end
      MIX_A_ADD: begin
        a_next = p2 + t2;
        b_next = p2;
      end
      MIX_B_ADD: begin
        a_next = p2;
        b_next = p2 + t2;
      end
      MIX_A_SUB: begin
        a_next = p2 - t2;
        b_next = p2;
      end
      MIX_SPIN: begin
        a_next = p2;
        b_next = -p2;
      end
      default: begin
        a_next = '0;
        b_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products by the selected gain; with zero throttle the turn axis feeds the spin product
      xg    <= x * signed'({1'b0, g});
      pg    <= (y == '0) ? (x * signed'({1'b0, g})) : (y * signed'({1'b0, g}));
      code1 <= code_next;

      p2    <= MIX_W'(pg) <<< FRAC;
      t2    <= xg * signed'({1'b0, turn_gain});
      code2 <= code1;

      a3 <= a_next;
      b3 <= b_next;

      na <= a3[MIX_W-1];
      nb <= b3[MIX_W-1];
      ma <= a3[MIX_W-1] ? MIX_W'(-a3) : MIX_W'(a3);
      mb <= b3[MIX_W-1] ? MIX_W'(-b3) : MIX_W'(b3);

      right_drive <= drive_round(na, ma, reverse_gain);
      left_drive  <= drive_round(nb, mb, reverse_gain);
    end
  end

endmodule
